>>> src/cg_pkg.sv
`default_nettype none

package cg_pkg;

  // Default sizes for the top level parameters.
  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int MAX_CHOOSE_DEF   = 16;

  // Depth of the command queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;

  // Field widths fixed by the interface.
  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 6;
  localparam int VALUE_W  = 32;
  localparam int SLOT_W   = 4;
  localparam int ACTIVE_W = 7;
  localparam int CHOOSE_W = 5;

  // Input mode codes.
  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEXT    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

  // Configuration register indexes (address bit 2).
  localparam logic REG_ACTIVE_COUNT = 1'b0;
  localparam logic REG_CHOOSE_COUNT = 1'b1;

  // Classified command carried from the front end to the back end.
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NEXT    = 2'd1,
    OP_RESTART = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [INDEX_W-1:0]   idx;
    logic [VALUE_W-1:0]   value;
  } cmd_t;

endpackage

`default_nettype wire

>>> src/cg_front.sv
`default_nettype none

module cg_front #(
  parameter int MAX_ELEMENTS = cg_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                          start,
  input  wire logic                          q_full,
  input  wire logic [cg_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [cg_pkg::INDEX_W-1:0]    in_entry_index,
  input  wire logic [cg_pkg::VALUE_W-1:0]    in_entry_value,
  output logic                               busy,
  output logic                               q_push,
  output cg_pkg::cmd_t                       q_cmd
);

  localparam logic [31:0] MAX_E32 = 32'(MAX_ELEMENTS);

  logic accept;
  logic keep;

  // A word is taken whenever the queue has room.
  assign busy   = q_full;
  assign accept = start && !q_full;

  // Sort the word into a command; loads out of range and unused modes are dropped.
  always_comb begin
    keep        = 1'b0;
    q_cmd.op    = cg_pkg::OP_LOAD;
    q_cmd.idx   = in_entry_index;
    q_cmd.value = in_entry_value;
    unique case (in_mode)
      cg_pkg::MODE_LOAD: begin
        q_cmd.op = cg_pkg::OP_LOAD;
        keep     = (32'(in_entry_index) < MAX_E32);
      end
      cg_pkg::MODE_NEXT: begin
        q_cmd.op = cg_pkg::OP_NEXT;
        keep     = 1'b1;
      end
      cg_pkg::MODE_RESTART: begin
        q_cmd.op = cg_pkg::OP_RESTART;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = accept && keep;

endmodule

`default_nettype wire

>>> src/cg_queue.sv
`default_nettype none

module cg_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire cg_pkg::cmd_t  wr_cmd,
  input  wire logic          pop,
  output cg_pkg::cmd_t       rd_cmd,
  output logic               empty,
  output logic               full
);

  localparam int DEPTH = cg_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  cg_pkg::cmd_t      slot_r [DEPTH];
  logic [AW-1:0]     wptr_r, wptr_nxt;
  logic [AW-1:0]     rptr_r, rptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign empty   = (count_r == CW'(0));
  assign full    = (count_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = slot_r[rptr_r];

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

>>> src/cg_back.sv
`default_nettype none

module cg_back #(
  parameter int MAX_ELEMENTS = cg_pkg::MAX_ELEMENTS_DEF,
  parameter int MAX_CHOOSE   = cg_pkg::MAX_CHOOSE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_empty,
  input  wire cg_pkg::cmd_t                   q_cmd,
  output logic                                q_pop,
  input  wire logic [cg_pkg::ACTIVE_W-1:0]    active_count,
  input  wire logic [cg_pkg::CHOOSE_W-1:0]    choose_count,
  output logic                                out_strobe,
  output logic                                out_found,
  output logic [cg_pkg::SLOT_W-1:0]           out_slot,
  output logic [cg_pkg::VALUE_W-1:0]          out_element_value,
  output logic                                out_last
);

  localparam int PW = $clog2(MAX_ELEMENTS);
  localparam int KW = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
  localparam int SW = ((PW > cg_pkg::ACTIVE_W) ? PW : cg_pkg::ACTIVE_W) + 1;
  localparam logic [31:0] MAX_E32 = 32'(MAX_ELEMENTS);
  localparam logic [31:0] MAX_C32 = 32'(MAX_CHOOSE);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic          vld;
    logic          none;
    logic [KW-1:0] k;
    logic          last;
  } issue_t;

  state_t                         state_r, state_nxt;
  logic                           started_r, started_nxt;
  logic                           exhausted_r, exhausted_nxt;
  logic [cg_pkg::ACTIVE_W-1:0]    n_r, n_nxt;
  logic [cg_pkg::CHOOSE_W-1:0]    m_r, m_nxt;
  logic [KW-1:0]                  f_r, f_nxt;
  logic [PW-1:0]                  b_r, b_nxt;
  logic [KW-1:0]                  k_r, k_nxt;
  logic [KW-1:0]                  iss_r, iss_nxt;
  logic                           iss_vld_r, iss_vld_nxt;
  logic [KW-1:0]                  sc_i_r, sc_i_nxt;
  logic                           sc_vld_r, sc_vld_nxt;
  issue_t                         s1_r, s1_nxt;

  // Element table and chosen position store.
  logic [cg_pkg::VALUE_W-1:0]     tbl_mem [MAX_ELEMENTS];
  logic [cg_pkg::VALUE_W-1:0]     tbl_rd_r;
  logic [PW-1:0]                  tbl_raddr;
  logic                           tbl_we;
  logic [PW-1:0]                  pos_mem [MAX_CHOOSE];
  logic [MAX_CHOOSE-1:0]          pos_vld_r;
  logic [PW-1:0]                  pos_mem_rd_r;
  logic                           pos_vld_rd_r;
  logic [PW-1:0]                  pos_rd;
  logic [KW-1:0]                  pos_raddr;
  logic                           pos_we;
  logic [PW-1:0]                  pos_wdata;

  logic [cg_pkg::ACTIVE_W-1:0]    n_cap;
  logic                           m_bad;
  logic                           scan_hit;
  logic                           emit_end;
  logic                           refill;

  logic                           out_strobe_r;
  logic                           out_found_r;
  logic [cg_pkg::SLOT_W-1:0]      out_slot_r;
  logic                           out_last_r;

  // Effective counts for a new request.
  always_comb begin
    n_cap = (32'(active_count) > MAX_E32) ? MAX_E32[cg_pkg::ACTIVE_W-1:0] : active_count;
    m_bad = (choose_count == '0) || (32'(choose_count) > MAX_C32) ||
            (n_cap < cg_pkg::ACTIVE_W'(choose_count));
  end

  // A checked position may still advance while pos + m < n + i.
  assign pos_rd   = pos_vld_rd_r ? pos_mem_rd_r : '0;
  assign scan_hit = (SW'(pos_rd) + SW'(m_r)) < (SW'(n_r) + SW'(sc_i_r));
  assign emit_end = (8'(k_r) == (8'(m_r) - 8'd1));

  // Sequencer: takes commands from the queue and walks scan and emit passes.
  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    exhausted_nxt = exhausted_r;
    n_nxt         = n_r;
    m_nxt         = m_r;
    f_nxt         = f_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    iss_nxt       = iss_r;
    iss_vld_nxt   = iss_vld_r;
    sc_i_nxt      = sc_i_r;
    sc_vld_nxt    = 1'b0;
    s1_nxt        = '0;
    q_pop         = 1'b0;
    tbl_we        = 1'b0;
    pos_raddr     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            cg_pkg::OP_LOAD: begin
              tbl_we = 1'b1;
            end
            cg_pkg::OP_RESTART: begin
              started_nxt   = 1'b0;
              exhausted_nxt = 1'b0;
            end
            cg_pkg::OP_NEXT: begin
              n_nxt = n_cap;
              m_nxt = choose_count;
              if (exhausted_r || m_bad) begin
                exhausted_nxt = 1'b1;
                s1_nxt.vld    = 1'b1;
                s1_nxt.none   = 1'b1;
                s1_nxt.last   = 1'b1;
              end else if (!started_r) begin
                // First subset: positions 0 .. m-1.
                started_nxt = 1'b1;
                f_nxt       = '0;
                b_nxt       = '0;
                k_nxt       = '0;
                state_nxt   = S_EMIT;
              end else begin
                iss_nxt     = KW'(choose_count - cg_pkg::CHOOSE_W'(1));
                iss_vld_nxt = 1'b1;
                state_nxt   = S_SCAN;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Issue reads right to left, one position a cycle.
        pos_raddr = iss_r;
        if (iss_vld_r) begin
          sc_vld_nxt = 1'b1;
          sc_i_nxt   = iss_r;
          if (iss_r == '0) begin
            iss_vld_nxt = 1'b0;
          end else begin
            iss_nxt = iss_r - KW'(1);
          end
        end
        // Check the position read in the previous cycle.
        if (sc_vld_r) begin
          if (scan_hit) begin
            f_nxt       = sc_i_r;
            b_nxt       = pos_rd + PW'(1);
            k_nxt       = '0;
            sc_vld_nxt  = 1'b0;
            iss_vld_nxt = 1'b0;
            state_nxt   = S_EMIT;
          end else if (sc_i_r == '0) begin
            exhausted_nxt = 1'b1;
            s1_nxt.vld    = 1'b1;
            s1_nxt.none   = 1'b1;
            s1_nxt.last   = 1'b1;
            sc_vld_nxt    = 1'b0;
            iss_vld_nxt   = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        // One chosen element enters the read pipeline each cycle.
        pos_raddr   = k_r;
        s1_nxt.vld  = 1'b1;
        s1_nxt.k    = k_r;
        s1_nxt.last = emit_end;
        if (emit_end) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Second stage: positions from the advance point on are refilled consecutively.
  always_comb begin
    refill    = (8'(s1_r.k) >= 8'(f_r));
    pos_wdata = b_r + PW'(s1_r.k - f_r);
    pos_we    = s1_r.vld && !s1_r.none && refill;
    tbl_raddr = refill ? pos_wdata : pos_rd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      started_r    <= 1'b0;
      exhausted_r  <= 1'b0;
      iss_vld_r    <= 1'b0;
      sc_vld_r     <= 1'b0;
      s1_r         <= '0;
      pos_vld_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      started_r    <= started_nxt;
      exhausted_r  <= exhausted_nxt;
      iss_vld_r    <= iss_vld_nxt;
      sc_vld_r     <= sc_vld_nxt;
      s1_r         <= s1_nxt;
      out_strobe_r <= s1_r.vld;
      if (pos_we) begin
        pos_vld_r[s1_r.k] <= 1'b1;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    m_r          <= m_nxt;
    f_r          <= f_nxt;
    b_r          <= b_nxt;
    k_r          <= k_nxt;
    iss_r        <= iss_nxt;
    sc_i_r       <= sc_i_nxt;
    out_found_r  <= !s1_r.none;
    out_slot_r   <= s1_r.none ? '0 : cg_pkg::SLOT_W'(s1_r.k);
    out_last_r   <= s1_r.last;
  end

  // Position store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[s1_r.k] <= pos_wdata;
    end
    pos_mem_rd_r <= pos_mem[pos_raddr];
    pos_vld_rd_r <= pos_vld_r[pos_raddr];
  end

  // Element table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[PW'(q_cmd.idx)] <= q_cmd.value;
    end
    tbl_rd_r <= tbl_mem[tbl_raddr];
  end

  assign out_strobe        = out_strobe_r;
  assign out_found         = out_found_r;
  assign out_slot          = out_slot_r;
  assign out_last          = out_last_r;
  assign out_element_value = out_found_r ? tbl_rd_r : '0;

endmodule

`default_nettype wire

>>> src/combination_generator.sv
// Channel     | Signals                                              | Handshake
// ------------+------------------------------------------------------+--------------------------
// input       | in_mode, in_entry_index, in_entry_value              | start high, busy low
// result      | out_found, out_slot, out_element_value, out_last     | out_strobe, one cycle
// config      | psel, penable, pwrite, paddr, pwdata, prdata, pready | APB write, pready high
//
// A load or restart word is handled by the back end in its idle state; words queue two deep behind it.
// A next request is decoded, then (except for the first subset) scans the position store
// (one read port) right to left, then emits m words, each through s1 and the output registers.
// A request refused at decode, or one that runs out of subsets in the scan, gives its
// single result through the s1 register and then the output registers.
// Reset is synchronous; the element table holds nothing defined until loaded.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module combination_generator #(
  parameter int MAX_ELEMENTS = cg_pkg::MAX_ELEMENTS_DEF,
  parameter int MAX_CHOOSE   = cg_pkg::MAX_CHOOSE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [cg_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [cg_pkg::INDEX_W-1:0]    in_entry_index,
  input  wire logic [cg_pkg::VALUE_W-1:0]    in_entry_value,
  output logic                               out_strobe,
  output logic                               out_found,
  output logic [cg_pkg::SLOT_W-1:0]          out_slot,
  output logic [cg_pkg::VALUE_W-1:0]         out_element_value,
  output logic                               out_last,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [cg_pkg::ACTIVE_W-1:0] active_count_r;
  logic [cg_pkg::CHOOSE_W-1:0] choose_count_r;
  logic                        cfg_we;
  logic                        q_full;
  logic                        q_empty;
  logic                        q_push;
  logic                        q_pop;
  cg_pkg::cmd_t                q_wcmd;
  cg_pkg::cmd_t                q_rcmd;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r <= '0;
      choose_count_r <= cg_pkg::CHOOSE_W'(1);
    end else if (cfg_we) begin
      unique case (paddr[2])
        cg_pkg::REG_ACTIVE_COUNT: active_count_r <= pwdata[cg_pkg::ACTIVE_W-1:0];
        cg_pkg::REG_CHOOSE_COUNT: choose_count_r <= pwdata[cg_pkg::CHOOSE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (paddr[2])
      cg_pkg::REG_ACTIVE_COUNT: prdata = 32'(active_count_r);
      cg_pkg::REG_CHOOSE_COUNT: prdata = 32'(choose_count_r);
      default:                  prdata = '0;
    endcase
  end

  cg_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_front (
    .start          (start),
    .q_full         (q_full),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .busy           (busy),
    .q_push         (q_push),
    .q_cmd          (q_wcmd)
  );

  cg_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (q_wcmd),
    .pop    (q_pop),
    .rd_cmd (q_rcmd),
    .empty  (q_empty),
    .full   (q_full)
  );

  cg_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_CHOOSE   (MAX_CHOOSE)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_cmd             (q_rcmd),
    .q_pop             (q_pop),
    .active_count      (active_count_r),
    .choose_count      (choose_count_r),
    .out_strobe        (out_strobe),
    .out_found         (out_found),
    .out_slot          (out_slot),
    .out_element_value (out_element_value),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

>>> src/cg_checker.sv
`default_nettype none

module cg_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          busy,
  input wire logic                          out_strobe,
  input wire logic                          out_found,
  input wire logic [cg_pkg::SLOT_W-1:0]     out_slot,
  input wire logic [cg_pkg::VALUE_W-1:0]    out_element_value,
  input wire logic                          out_last
);

  // A no-subset word is a lone, final word with zero payload.
  a_none_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_found |->
      out_last && (out_slot == '0) && (out_element_value == '0))
    else $error("no-subset word is not a lone zero word");

  // Words of one subset arrive on consecutive cycles with rising slots.
  a_subset_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=>
      out_strobe && out_found && (out_slot == cg_pkg::SLOT_W'($past(out_slot) + 1'b1)))
    else $error("subset words broken or out of order");

  // Nothing comes out right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result word right after reset");

  // The queue is empty after reset, so words are taken.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !busy)
    else $error("busy right after reset");

endmodule

bind combination_generator cg_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_found         (out_found),
  .out_slot          (out_slot),
  .out_element_value (out_element_value),
  .out_last          (out_last)
);

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // Mode 3 has no meaning and must be dropped by the block.
  localparam logic [cg_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int TABLE_DEPTH = 64;
  localparam int PICK_DEPTH  = 16;
  localparam int SCRIPT_LEN  = 28;

  typedef struct packed {
    logic                       found;
    logic [cg_pkg::SLOT_W-1:0]  slot;
    logic [cg_pkg::VALUE_W-1:0] value;
    logic                       last;
  } subset_word_t;

  // The answer to a request when no subset is left.
  localparam subset_word_t NO_SUBSET = {1'b0, 4'd0, 32'd0, 1'b1};

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [cg_pkg::MODE_W-1:0]  mode;
    logic [cg_pkg::INDEX_W-1:0] idx;    // register index on ROW_REG rows
    logic [cg_pkg::VALUE_W-1:0] value;
    logic                       no_subset;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [cg_pkg::MODE_W-1:0] in_mode = '0;
  logic [cg_pkg::INDEX_W-1:0] in_entry_index = '0;
  logic [cg_pkg::VALUE_W-1:0] in_entry_value = '0;
  logic out_strobe;
  logic out_found;
  logic [cg_pkg::SLOT_W-1:0] out_slot;
  logic [cg_pkg::VALUE_W-1:0] out_element_value;
  logic out_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Mirror of the block state used to forecast results.
  logic [cg_pkg::VALUE_W-1:0] mirror_table [TABLE_DEPTH];
  int mirror_picks [PICK_DEPTH];
  bit mirror_started;
  bit mirror_done;
  logic [cg_pkg::ACTIVE_W-1:0] mirror_active;
  logic [cg_pkg::CHOOSE_W-1:0] mirror_choose;
  bit [TABLE_DEPTH-1:0] loaded;
  int loaded_prefix;

  subset_word_t due_words [$];
  subset_word_t fresh_words [$];
  subset_word_t want_word;
  subset_word_t seen_word;
  int mismatches;
  int idle_pct;
  row_t script [0:SCRIPT_LEN-1];

  combination_generator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_entry_index    (in_entry_index),
    .in_entry_value    (in_entry_value),
    .out_strobe        (out_strobe),
    .out_found         (out_found),
    .out_slot          (out_slot),
    .out_element_value (out_element_value),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk = ~clk;

  // Forecast the words one accepted input word causes, into fresh_words.
  function automatic void forecast_subset(logic [cg_pkg::MODE_W-1:0] mode,
                                          logic [cg_pkg::INDEX_W-1:0] idx,
                                          logic [cg_pkg::VALUE_W-1:0] value);
    int n;
    int m;
    int i;
    int j;
    int k;
    bit moved;
    fresh_words.delete();
    case (mode)
      cg_pkg::MODE_LOAD: begin
        mirror_table[idx] = value;
        loaded[idx] = 1'b1;
        while (loaded_prefix < TABLE_DEPTH && loaded[loaded_prefix])
          loaded_prefix++;
      end
      cg_pkg::MODE_RESTART: begin
        mirror_started = 1'b0;
        mirror_done = 1'b0;
      end
      cg_pkg::MODE_NEXT: begin
        n = int'(mirror_active);
        m = int'(mirror_choose);
        if (n > TABLE_DEPTH)
          n = TABLE_DEPTH;
        if (mirror_done) begin
          fresh_words = {fresh_words, NO_SUBSET};
        end else if (m == 0 || m > PICK_DEPTH || n < m) begin
          mirror_done = 1'b1;
          fresh_words = {fresh_words, NO_SUBSET};
        end else begin
          moved = 1'b0;
          if (!mirror_started) begin
            for (k = 0; k < m; k++)
              mirror_picks[k] = k;
            mirror_started = 1'b1;
            moved = 1'b1;
          end else begin
            // Step the rightmost position that still has room, refill to its right.
            i = m;
            while (i > 0 && !moved) begin
              i--;
              if (mirror_picks[i] + m < n + i) begin
                mirror_picks[i]++;
                for (j = i + 1; j < m; j++)
                  mirror_picks[j] = mirror_picks[j-1] + 1;
                moved = 1'b1;
              end
            end
          end
          if (moved) begin
            for (k = 0; k < m; k++)
              fresh_words = {fresh_words, subset_word_t'({1'b1, k[cg_pkg::SLOT_W-1:0],
                             mirror_table[mirror_picks[k]], (k == m - 1)})};
          end else begin
            mirror_done = 1'b1;
            fresh_words = {fresh_words, NO_SUBSET};
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Send one input word, with a random gap in front of it.
  task automatic send_word(logic [cg_pkg::MODE_W-1:0] mode,
                           logic [cg_pkg::INDEX_W-1:0] idx,
                           logic [cg_pkg::VALUE_W-1:0] value, bit no_subset);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_entry_index <= idx;
    in_entry_value <= value;
    do @(posedge clk); while (busy);
    forecast_subset(mode, idx, value);
    if (no_subset)
      due_words = {due_words, NO_SUBSET};
    else
      foreach (fresh_words[q])
        due_words = {due_words, fresh_words[q]};
  endtask

  // Stop sending and let the block run dry, including queued loads and restarts.
  task automatic drain_words();
    start <= 1'b0;
    while (due_words.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write one register, then read it back.
  task automatic write_reg(logic sel, logic [31:0] data);
    logic [31:0] held;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == cg_pkg::REG_ACTIVE_COUNT) begin
      mirror_active = data[cg_pkg::ACTIVE_W-1:0];
      held = {25'd0, mirror_active};
    end else begin
      mirror_choose = data[cg_pkg::CHOOSE_W-1:0];
      held = {27'd0, mirror_choose};
    end
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== held) begin
      mismatches++;
      $display("%0t: register %0d read back: expected %h, got %h", $time, sel, held, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Check every result word against the oldest forecast.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      seen_word = {out_found, out_slot, out_element_value, out_last};
      if (due_words.size() == 0) begin
        mismatches++;
        $display("%0t: word with nothing expected: found=%0d slot=%0d value=%h last=%0d",
                 $time, seen_word.found, seen_word.slot, seen_word.value, seen_word.last);
      end else begin
        want_word = due_words.pop_front();
        if (seen_word.found !== want_word.found || seen_word.slot !== want_word.slot ||
            seen_word.value !== want_word.value || seen_word.last !== want_word.last) begin
          mismatches++;
          $write("%0t: expected found=%0d slot=%0d value=%h last=%0d, ",
                 $time, want_word.found, want_word.slot, want_word.value, want_word.last);
          $display("got found=%0d slot=%0d value=%h last=%0d",
                   seen_word.found, seen_word.slot, seen_word.value, seen_word.last);
        end
      end
    end
  end

  // Give up if the block hangs.
  initial begin
    #5_000_000;
    $display("combination_generator regression: fail");
    $finish;
  end

  initial begin
    int ph;
    int n;
    int m;
    int r;
    int lim;
    mismatches = 0;
    idle_pct = 27;
    mirror_started = 1'b0;
    mirror_done = 1'b0;
    mirror_active = '0;
    mirror_choose = 5'd1;
    loaded = '0;
    loaded_prefix = 0;
    foreach (mirror_picks[q])
      mirror_picks[q] = 0;
    foreach (mirror_table[q])
      mirror_table[q] = '0;

    script = '{
      // After reset there are no elements, and the block then stays exhausted.
      '{ROW_WORD, cg_pkg::MODE_NEXT,    6'd0,  32'h0000_0000, 1'b1},
      '{ROW_WORD, cg_pkg::MODE_NEXT,    6'd0,  32'h0000_0000, 1'b1},
      '{ROW_WORD, cg_pkg::MODE_RESTART, 6'd0,  32'h0000_0000, 1'b0},
      '{ROW_WORD, cg_pkg::MODE_LOAD,    6'd0,  32'h0000_0000, 1'b0},
      '{ROW_WORD, cg_pkg::MODE_LOAD,    6'd1,  32'hFFFF_FFFF, 1'b0},
      '{ROW_WORD, cg_pkg::MODE_LOAD,    6'd2,  32'hA5A5_5A5A, 1'b0},
      '{ROW_WORD, cg_pkg::MODE_LOAD,    6'd63, 32'h8000_0001, 1'b0},
      // The spare mode must not overwrite entry 0.
      '{ROW_WORD, MODE_SPARE,           6'd0,  32'h1234_5678, 1'b0},
      '{ROW_REG,  cg_pkg::MODE_LOAD, {5'd0, cg_pkg::REG_ACTIVE_COUNT}, 32'd3, 1'b0},
      '{ROW_REG,  cg_pkg::MODE_LOAD, {5'd0, cg_pkg::REG_CHOOSE_COUNT}, 32'd2, 1'b0},
      '{ROW_WORD, cg_pkg::MODE_NEXT,    6'd0,  32'h0000_0000, 1'b0},
      '{ROW_WORD, cg_pkg::MODE_NEXT,    6'd0,  32'h0000_0000, 1'b0},
      '{ROW_WORD, cg_pkg::MODE_NEXT,    6'd0,  32'h0000_0000, 1'b0},
      '{ROW_WORD, cg_pkg::MODE_NEXT,    6'd0,  32'h0000_0000, 1'b1},
      '{ROW_WORD, cg_pkg::MODE_NEXT,    6'd0,  32'h0000_0000, 1'b1},
      '{ROW_WORD, cg_pkg::MODE_RESTART, 6'd0,  32'h0000_0000, 1'b0},
      // A subset size of zero, then one above the limit.
      '{ROW_REG,  cg_pkg::MODE_LOAD, {5'd0, cg_pkg::REG_CHOOSE_COUNT}, 32'd0, 1'b0},
      '{ROW_WORD, cg_pkg::MODE_NEXT,    6'd0,  32'h0000_0000, 1'b1},
      '{ROW_WORD, cg_pkg::MODE_RESTART, 6'd0,  32'h0000_0000, 1'b0},
      '{ROW_REG,  cg_pkg::MODE_LOAD, {5'd0, cg_pkg::REG_CHOOSE_COUNT}, 32'd31, 1'b0},
      '{ROW_WORD, cg_pkg::MODE_NEXT,    6'd0,  32'h0000_0000, 1'b1},
      '{ROW_WORD, cg_pkg::MODE_RESTART, 6'd0,  32'h0000_0000, 1'b0},
      // Change the subset size in the middle of a sequence.
      '{ROW_REG,  cg_pkg::MODE_LOAD, {5'd0, cg_pkg::REG_CHOOSE_COUNT}, 32'd1, 1'b0},
      '{ROW_WORD, cg_pkg::MODE_NEXT,    6'd0,  32'h0000_0000, 1'b0},
      '{ROW_REG,  cg_pkg::MODE_LOAD, {5'd0, cg_pkg::REG_CHOOSE_COUNT}, 32'd3, 1'b0},
      '{ROW_WORD, cg_pkg::MODE_NEXT,    6'd0,  32'h0000_0000, 1'b0},
      '{ROW_WORD, cg_pkg::MODE_NEXT,    6'd0,  32'h0000_0000, 1'b0},
      '{ROW_WORD, cg_pkg::MODE_RESTART, 6'd0,  32'h0000_0000, 1'b0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    for (int row = 0; row < SCRIPT_LEN; row++) begin
      if (script[row].kind == ROW_REG) begin
        drain_words();
        write_reg(script[row].idx[0], script[row].value);
      end else begin
        send_word(script[row].mode, script[row].idx, script[row].value,
                  script[row].no_subset);
      end
    end

    // Random part: each phase sets both registers while the block is idle.
    for (ph = 0; ph < 12; ph++) begin
      idle_pct = (ph < 4) ? 27 : ((ph < 8) ? 60 : 0);
      // The widest settings read the whole table, so fill it first.
      if (ph == 7 || ph == 11)
        while (loaded_prefix < TABLE_DEPTH)
          send_word(cg_pkg::MODE_LOAD, loaded_prefix[cg_pkg::INDEX_W-1:0], $urandom, 1'b0);
      drain_words();
      if (ph == 7) begin
        n = TABLE_DEPTH;
        m = PICK_DEPTH;
      end else if (ph == 11) begin
        n = 127;
        m = 1;
      end else begin
        r = $urandom_range(99);
        lim = (loaded_prefix < 8) ? loaded_prefix : 8;
        if (r < 70) begin
          n = $urandom_range(lim, 0);
          m = $urandom_range(6, 1);
        end else if (r < 90) begin
          n = $urandom_range(loaded_prefix, 0);
          m = $urandom_range(PICK_DEPTH, 1);
        end else begin
          n = $urandom_range(loaded_prefix, 0);
          m = $urandom_range(1) ? 0 : $urandom_range(31, 17);
        end
      end
      write_reg(cg_pkg::REG_ACTIVE_COUNT, n);
      write_reg(cg_pkg::REG_CHOOSE_COUNT, m);

      repeat (30) begin
        if ($urandom_range(99) < 2)
          drain_words();
        r = $urandom_range(99);
        if (mirror_done && r < 50)
          send_word(cg_pkg::MODE_RESTART, cg_pkg::INDEX_W'($urandom), $urandom, 1'b0);
        else if (r < 62)
          send_word(cg_pkg::MODE_NEXT, cg_pkg::INDEX_W'($urandom), $urandom, 1'b0);
        else if (r < 82)
          send_word(cg_pkg::MODE_LOAD,
                    (loaded_prefix < TABLE_DEPTH && $urandom_range(99) < 70) ?
                      loaded_prefix[cg_pkg::INDEX_W-1:0] :
                      cg_pkg::INDEX_W'($urandom_range(63)),
                    $urandom, 1'b0);
        else if (r < 95)
          send_word(cg_pkg::MODE_RESTART, cg_pkg::INDEX_W'($urandom), $urandom, 1'b0);
        else
          send_word(MODE_SPARE, cg_pkg::INDEX_W'($urandom), $urandom, 1'b0);
      end
    end

    // Let everything come out, then watch a little longer for strays.
    drain_words();
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("combination_generator regression: pass");
    else
      $display("combination_generator regression: fail");
    $finish;
  end

endmodule
